// ----- design/coalescing_message_queue_top_macros.svh -----
// Assertion macros for the coalescing message queue.
`ifndef COALESCING_MESSAGE_QUEUE_TOP_MACROS_SVH
`define COALESCING_MESSAGE_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CMQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cmq_pkg.sv -----
// Shared types and constants of the coalescing message queue.
`default_nettype none
package cmq_pkg;

  localparam int unsigned DEPTH_DEF = 256;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned STATUS_W = 3;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_PLAIN = 2'd0;
  localparam kind_t KIND_COAL  = 2'd1;
  localparam kind_t KIND_POP   = 2'd2;
  localparam kind_t KIND_QUIT  = 2'd3;

  localparam status_t ST_ACCEPTED = 3'd0;
  localparam status_t ST_FULL     = 3'd1;
  localparam status_t ST_DUP      = 3'd2;
  localparam status_t ST_POPPED   = 3'd3;
  localparam status_t ST_QUIT     = 3'd4;
  localparam status_t ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] lng;
    logic [WORD_W-1:0] tag;
    logic [WIN_W-1:0]  window;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

endpackage
`default_nettype wire

// ----- design/cmq_in_if.sv -----
// Request channel of the coalescing message queue.
`default_nettype none
interface cmq_in_if;
  logic                         valid;
  logic                         ready;
  logic [cmq_pkg::KIND_W-1:0]   kind;
  logic [cmq_pkg::CODE_W-1:0]   msg_code;
  logic [cmq_pkg::WORD_W-1:0]   word_param;
  logic [cmq_pkg::WORD_W-1:0]   long_param;
  logic [cmq_pkg::WORD_W-1:0]   tag;
  logic [cmq_pkg::WIN_W-1:0]    window;

  modport source (output valid, kind, msg_code, word_param, long_param, tag, window,
                  input ready);
  modport sink (input valid, kind, msg_code, word_param, long_param, tag, window,
                output ready);
endinterface
`default_nettype wire

// ----- design/cmq_out_if.sv -----
// Result channel of the coalescing message queue.
`default_nettype none
interface cmq_out_if;
  logic                         valid;
  logic                         ready;
  logic [cmq_pkg::STATUS_W-1:0] status;
  logic [cmq_pkg::CODE_W-1:0]   out_code;
  logic [cmq_pkg::WORD_W-1:0]   out_word;
  logic [cmq_pkg::WORD_W-1:0]   out_long;
  logic [cmq_pkg::WORD_W-1:0]   out_tag;
  logic [cmq_pkg::WIN_W-1:0]    out_window;

  modport source (output valid, status, out_code, out_word, out_long, out_tag, out_window,
                  input ready);
  modport sink (input valid, status, out_code, out_word, out_long, out_tag, out_window,
                output ready);
endinterface
`default_nettype wire

// ----- design/cmq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cmq_ram #(
  parameter int unsigned WIDTH = cmq_pkg::SLOT_W,
  parameter int unsigned DEPTH = cmq_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/coalescing_message_queue_top.sv -----
// Coalescing message queue top level: a circular FIFO of DEPTH slots in one RAM
// that holds at most DEPTH-1 messages, with a sticky quit flag and a coalescing post
// that drops duplicates. Each request gives exactly one result. Plain posts, quit
// requests, and pops that deliver a quit or find the queue empty are answered straight
// from idle; a pop of a stored message passes through the pop state for its RAM read.
// A coalescing post on a queue that is not full passes through the scan state, where
// one comparator walks the pending slots through the single
// RAM read port, one slot per cycle, and stops early on a match. A request is taken
// only while the sequencer is idle and the result register is free or being emptied.
// The slot RAM needs no clearing after reset.
`default_nettype none
`include "coalescing_message_queue_top_macros.svh"
module coalescing_message_queue_top #(
  parameter int unsigned DEPTH = cmq_pkg::DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  cmq_in_if.sink                          in_if,
  cmq_out_if.source                       out_if,
  input  wire logic                       cfg_we,
  input  wire logic [cmq_pkg::CODE_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;

  function automatic idx_t next_idx(input idx_t i);
    next_idx = (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  logic [1:0] state_r, state_nxt;
  idx_t rd_idx_r, rd_idx_nxt;
  idx_t wr_idx_r, wr_idx_nxt;
  idx_t scan_idx_r, scan_idx_nxt;
  logic pend_r, pend_nxt;
  logic quit_r, quit_nxt;
  logic [cmq_pkg::CODE_W-1:0] coal_r;

  cmq_pkg::slot_t hold_r, in_slot, ram_wdata, ram_rdata;
  logic ram_we;
  idx_t ram_raddr;

  logic out_valid_r, out_valid_nxt, out_load;
  cmq_pkg::status_t out_status_r, out_status_nxt;
  cmq_pkg::slot_t out_slot_r, out_slot_nxt;

  logic accept, full, empty, hit;

  assign accept  = in_if.valid && in_if.ready;
  assign full    = (next_idx(wr_idx_r) == rd_idx_r);
  assign empty   = (rd_idx_r == wr_idx_r);
  assign in_if.ready = rst_n && (state_r == S_IDLE) && (!out_valid_r || out_if.ready);

  assign in_slot = '{code: in_if.msg_code, word: in_if.word_param, lng: in_if.long_param,
                     tag: in_if.tag, window: in_if.window};

  assign hit = (ram_rdata.code == hold_r.code) &&
               ((hold_r.code == coal_r) ||
                (ram_rdata.word == hold_r.word && ram_rdata.lng == hold_r.lng &&
                 ram_rdata.tag == hold_r.tag));

  assign ram_raddr = (state_r == S_IDLE) ? rd_idx_r : scan_idx_r;

  cmq_ram #(.WIDTH(cmq_pkg::SLOT_W), .DEPTH(DEPTH)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    scan_idx_nxt   = scan_idx_r;
    pend_nxt       = 1'b0;
    quit_nxt       = quit_r;
    ram_we         = 1'b0;
    ram_wdata      = in_slot;
    out_load       = 1'b0;
    out_status_nxt = cmq_pkg::ST_ACCEPTED;
    out_slot_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_if.kind)
            cmq_pkg::KIND_PLAIN: begin
              out_load = 1'b1;
              if (full) begin
                out_status_nxt = cmq_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                wr_idx_nxt = next_idx(wr_idx_r);
              end
            end
            cmq_pkg::KIND_COAL: begin
              if (full) begin
                out_load       = 1'b1;
                out_status_nxt = cmq_pkg::ST_FULL;
              end else begin
                state_nxt    = S_SCAN;
                scan_idx_nxt = rd_idx_r;
              end
            end
            cmq_pkg::KIND_POP: begin
              if (quit_r) begin
                out_load            = 1'b1;
                out_status_nxt      = cmq_pkg::ST_QUIT;
                out_slot_nxt.window = in_if.window;
                quit_nxt            = 1'b0;
              end else if (empty) begin
                out_load       = 1'b1;
                out_status_nxt = cmq_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_POP;
              end
            end
            cmq_pkg::KIND_QUIT: begin
              out_load = 1'b1;
              quit_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_idx_r != wr_idx_r) begin
          pend_nxt     = 1'b1;
          scan_idx_nxt = next_idx(scan_idx_r);
        end
        if (pend_r && hit) begin
          out_load       = 1'b1;
          out_status_nxt = cmq_pkg::ST_DUP;
          pend_nxt       = 1'b0;
          state_nxt      = S_IDLE;
        end else if (!pend_r && scan_idx_r == wr_idx_r) begin
          ram_we     = 1'b1;
          ram_wdata  = hold_r;
          wr_idx_nxt = next_idx(wr_idx_r);
          out_load   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_POP: begin
        out_load       = 1'b1;
        out_status_nxt = cmq_pkg::ST_POPPED;
        out_slot_nxt   = ram_rdata;
        rd_idx_nxt     = next_idx(rd_idx_r);
        state_nxt      = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      scan_idx_r  <= '0;
      pend_r      <= 1'b0;
      quit_r      <= 1'b0;
      coal_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      scan_idx_r  <= scan_idx_nxt;
      pend_r      <= pend_nxt;
      quit_r      <= quit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        coal_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= in_slot;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_slot_r   <= out_slot_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.out_code   = out_slot_r.code;
  assign out_if.out_word   = out_slot_r.word;
  assign out_if.out_long   = out_slot_r.lng;
  assign out_if.out_tag    = out_slot_r.tag;
  assign out_if.out_window = out_slot_r.window;

  `CMQ_ASSERT_NEXT(a_item_progress, clk, rst_n, accept, (state_r != S_IDLE) || out_valid_r, "accepted item neither in progress nor answered")
  `CMQ_ASSERT_NOW(a_no_overfill, clk, rst_n, ram_we, !full, "slot write into a full queue")
  `CMQ_ASSERT_NOW(a_read_in_scan, clk, rst_n, pend_r, state_r == S_SCAN, "scan read pending outside the scan")
  `CMQ_ASSERT_NOW(a_result_slot_free, clk, rst_n, out_load, !out_valid_r || out_if.ready, "result register overwritten")

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// Testbench for coalescing_message_queue_top: directed and random traffic checked against a behavioral queue.
module tb_top;
  import cmq_pkg::*;

  localparam int unsigned SLOTS         = DEPTH_DEF;
  localparam int unsigned HALF_PERIOD   = 2;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned SETTLE_CYCLES = SLOTS + 40;
  localparam int unsigned TIMEOUT       = 6_000_000;
  localparam int unsigned PHASE_ITEMS   = 110;

  typedef struct packed {
    kind_t             kind;
    logic [CODE_W-1:0] code;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] lng;
    logic [WORD_W-1:0] tag;
    logic [WIN_W-1:0]  window;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [CODE_W-1:0] code;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] lng;
    logic [WORD_W-1:0] tag;
    logic [WIN_W-1:0]  window;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CODE_W-1:0] cfg_wdata;

  cmq_in_if  in_ch ();
  cmq_out_if out_ch ();

  coalescing_message_queue_top #(.DEPTH(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // queue state as the block should hold it
  slot_t             mdl_slots [SLOTS];
  int unsigned       mdl_rd   = 0;
  int unsigned       mdl_wr   = 0;
  bit                mdl_quit = 1'b0;
  logic [CODE_W-1:0] mdl_coal = '0;

  outcome_t    expected_outcomes [$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned burst_left = 0;
  int unsigned status_seen [6] = '{default: 0};
  bit          rx_ready_run = 1'b1;
  int unsigned rx_run_left = 0;

  always #(HALF_PERIOD) clk = ~clk;

  function automatic int unsigned next_slot(int unsigned i);
    return (i + 1) % SLOTS;
  endfunction

  function automatic outcome_t apply_request(request_t r);
    outcome_t    res;
    int unsigned i;
    bit          hit;
    res = '0;
    hit = 1'b0;
    case (r.kind)
      KIND_PLAIN, KIND_COAL: begin
        if (next_slot(mdl_wr) == mdl_rd) begin
          res.status = ST_FULL;
        end else begin
          if (r.kind == KIND_COAL) begin
            i = mdl_rd;
            while (i != mdl_wr && !hit) begin
              if (mdl_slots[i].code == r.code &&
                  (r.code == mdl_coal ||
                   (mdl_slots[i].word == r.word && mdl_slots[i].lng == r.lng &&
                    mdl_slots[i].tag == r.tag)))
                hit = 1'b1;
              i = next_slot(i);
            end
          end
          if (hit) begin
            res.status = ST_DUP;
          end else begin
            mdl_slots[mdl_wr] = '{code: r.code, word: r.word, lng: r.lng, tag: r.tag,
                                  window: r.window};
            mdl_wr = next_slot(mdl_wr);
            res.status = ST_ACCEPTED;
          end
        end
      end
      KIND_POP: begin
        if (mdl_quit) begin
          mdl_quit = 1'b0;
          res.status = ST_QUIT;
          res.window = r.window;
        end else if (mdl_rd != mdl_wr) begin
          res.status = ST_POPPED;
          res.code   = mdl_slots[mdl_rd].code;
          res.word   = mdl_slots[mdl_rd].word;
          res.lng    = mdl_slots[mdl_rd].lng;
          res.tag    = mdl_slots[mdl_rd].tag;
          res.window = mdl_slots[mdl_rd].window;
          mdl_rd = next_slot(mdl_rd);
        end else begin
          res.status = ST_EMPTY;
        end
      end
      default: begin
        mdl_quit = 1'b1;
        res.status = ST_ACCEPTED;
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function automatic request_t make_request(kind_t k, logic [CODE_W-1:0] code,
                                            logic [WORD_W-1:0] word, logic [WORD_W-1:0] lng,
                                            logic [WORD_W-1:0] tag, logic [WIN_W-1:0] window);
    return '{kind: k, code: code, word: word, lng: lng, tag: tag, window: window};
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 32'h5555_5555;
      3: return 32'hAAAA_AAAA;
      default: return $urandom;
    endcase
  endfunction

  // results are checked first; a result never belongs to an item taken at the same edge
  always @(posedge clk) begin : scoreboard
    outcome_t want;
    request_t req;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_outcomes.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, status %0d", $time, out_ch.status);
        end else begin
          want = expected_outcomes.pop_front();
          check_field("status", WORD_W'(want.status), WORD_W'(out_ch.status));
          check_field("out_code", WORD_W'(want.code), WORD_W'(out_ch.out_code));
          check_field("out_word", want.word, out_ch.out_word);
          check_field("out_long", want.lng, out_ch.out_long);
          check_field("out_tag", want.tag, out_ch.out_tag);
          check_field("out_window", WORD_W'(want.window), WORD_W'(out_ch.out_window));
        end
        if (out_ch.status <= ST_EMPTY) status_seen[out_ch.status]++;
      end
      if (in_ch.valid && in_ch.ready) begin
        req = make_request(in_ch.kind, in_ch.msg_code, in_ch.word_param, in_ch.long_param,
                           in_ch.tag, in_ch.window);
        expected_outcomes.push_back(apply_request(req));
      end
    end
  end

  always @(posedge clk) begin
    if (rx_run_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          rx_ready_run = 1'b1;
          rx_run_left  = $urandom_range(20, 80);
        end
        3: begin
          rx_ready_run = 1'b0;
          rx_run_left  = $urandom_range(5, 12);
        end
        default: begin
          rx_ready_run = ~rx_ready_run;
          rx_run_left  = $urandom_range(0, 3);
        end
      endcase
    end else begin
      rx_run_left--;
    end
    out_ch.ready <= rx_ready_run;
  end

  task automatic send_item(request_t r);
    int unsigned gap;
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= r.kind;
    in_ch.msg_code   <= r.code;
    in_ch.word_param <= r.word;
    in_ch.long_param <= r.lng;
    in_ch.tag        <= r.tag;
    in_ch.window     <= r.window;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(0, 3))
        0: gap = 0;
        3: gap = $urandom_range(4, 10);
        default: gap = $urandom_range(1, 3);
      endcase
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_outcomes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_coalesce(logic [CODE_W-1:0] value);
    wait_idle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    mdl_coal = value;
  endtask

  task automatic test_directed();
    set_coalesce(16'hFFFF);
    send_item(make_request(KIND_POP, 16'h1234, '1, '1, '1, 16'hFFFF));
    send_item(make_request(KIND_QUIT, '0, '0, '0, '0, '0));
    send_item(make_request(KIND_QUIT, '1, '1, '1, '1, '1));
    send_item(make_request(KIND_POP, '0, '0, '0, '0, 16'hFFFF));
    send_item(make_request(KIND_POP, '0, '0, '0, '0, 16'h0001));
    send_item(make_request(KIND_PLAIN, 16'hFFFF, '1, '1, '1, 16'hFFFF));
    send_item(make_request(KIND_PLAIN, '0, '0, '0, '0, '0));
    // window is not part of the duplicate match
    send_item(make_request(KIND_COAL, '0, '0, '0, '0, 16'hBEEF));
    send_item(make_request(KIND_COAL, 16'hFFFF, 32'h1, 32'h2, 32'h3, 16'h4));
    send_item(make_request(KIND_COAL, '0, 32'h1, '0, '0, '0));
    send_item(make_request(KIND_PLAIN, '0, '0, '0, '0, 16'h0002));
    send_item(make_request(KIND_COAL, '0, '0, '0, 32'h8000_0000, '0));
    send_item(make_request(KIND_COAL, '0, '0, 32'h1, '0, '0));
    // quit jumps ahead of queued messages without dropping them
    send_item(make_request(KIND_QUIT, '0, '0, '0, '0, '0));
    send_item(make_request(KIND_POP, '0, '0, '0, '0, 16'h1234));
    repeat (7) send_item(make_request(KIND_POP, '1, '1, '1, '1, 16'h8000));
  endtask

  task automatic test_fill_to_full();
    request_t    first_post;
    request_t    r;
    int unsigned i;
    set_coalesce(16'h0000);
    for (i = 0; i < SLOTS + 1; i++) begin
      r = make_request((i % 3 == 2) ? KIND_COAL : KIND_PLAIN, 16'h1000 + i[15:0], $urandom,
                       $urandom, $urandom, i[15:0]);
      if (i == 0) first_post = r;
      send_item(r);
    end
    // full wins over the duplicate scan
    first_post.kind = KIND_COAL;
    send_item(first_post);
    send_item(make_request(KIND_COAL, 16'h0000, '0, '0, '0, '0));
    send_item(make_request(KIND_QUIT, '0, '0, '0, '0, '0));
    for (i = 0; i < SLOTS + 1; i++)
      send_item(make_request(KIND_POP, CODE_W'($urandom), $urandom, $urandom, $urandom,
                             WIN_W'($urandom)));
  endtask

  task automatic test_random_traffic();
    request_t    r;
    request_t    last_post;
    bit          have_last;
    int unsigned p;
    int unsigned post_pct;
    int unsigned roll;
    have_last = 1'b0;
    for (p = 0; p < 4; p++) begin
      case (p)
        1: set_coalesce(16'hFFFF);
        2: set_coalesce(16'h0000);
        default: set_coalesce(CODE_W'($urandom_range(1, 16'hFFFE)));
      endcase
      post_pct = (p % 2 == 0) ? 70 : 40;
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        r = make_request(KIND_POP, CODE_W'($urandom), $urandom, $urandom, $urandom,
                         WIN_W'($urandom));
        if (roll < post_pct) begin
          if (have_last && $urandom_range(0, 3) == 0) begin
            r = last_post;
            r.window = WIN_W'($urandom);
          end else begin
            case ($urandom_range(0, 5))
              0: r.code = mdl_coal;
              1: r.code = 16'h0000;
              2: r.code = 16'hFFFF;
              3: r.code = 16'h00FF;
              default: r.code = CODE_W'($urandom);
            endcase
            r.word = pick_word();
            r.lng  = pick_word();
            r.tag  = pick_word();
          end
          r.kind = ($urandom_range(0, 9) < 6) ? KIND_COAL : KIND_PLAIN;
          last_post = r;
          have_last = 1'b1;
        end else if (roll < post_pct + 6) begin
          r.kind = KIND_QUIT;
        end
        send_item(r);
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.kind       <= KIND_PLAIN;
    in_ch.msg_code   <= '0;
    in_ch.word_param <= '0;
    in_ch.long_param <= '0;
    in_ch.tag        <= '0;
    in_ch.window     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_fill_to_full();
    test_random_traffic();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d requests over six coalesce settings: %0d accepted, %0d full, %0d duplicates,",
             sent, status_seen[ST_ACCEPTED], status_seen[ST_FULL], status_seen[ST_DUP]);
    $display("%0d messages popped, %0d quits delivered, %0d empty pops, %0d mismatches.",
             status_seen[ST_POPPED], status_seen[ST_QUIT], status_seen[ST_EMPTY], errors);
    if (errors == 0 && expected_outcomes.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("Timed out with %0d results outstanding", expected_outcomes.size());
    $display("FAIL");
    $finish;
  end

endmodule
